// ===== src/bcpq_pkg.sv =====
// Shared constants, command codes and types for the bucket counting priority queue.
// Used by bcpq_pick, the top level and the checker; depends on nothing.
package bcpq_pkg;

    localparam int VALUE_W   = 4;
    localparam int NBUCKETS  = 1 << VALUE_W;
    localparam int ADDR_W    = $clog2(NBUCKETS);
    localparam int MAX_VALUE = 15;
    localparam int COUNT_W   = 32;
    localparam int TOTAL_W   = 32;
    localparam int CMD_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] idx;
    } t_pick;

    // buckets a get may hand out: 1 up to MAX_VALUE
    function automatic logic [NBUCKETS-1:0] pick_mask();
        logic [NBUCKETS-1:0] m;
        m = '0;
        for (int v = 0; v < NBUCKETS; v++) begin
            m[v] = (v >= 1) && (v <= MAX_VALUE);
        end
        return m;
    endfunction

    localparam logic [NBUCKETS-1:0] PICK_MASK = pick_mask();

endpackage

// ===== src/bcpq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bcpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/bcpq_pick.sv =====
// Lowest-set-bit search over the nonzero bucket map, limited to values 1..MAX_VALUE.
// Depends on bcpq_pkg.
module bcpq_pick (
    input  logic [bcpq_pkg::NBUCKETS-1:0] i_map,
    output bcpq_pkg::t_pick               o_pick
);
    import bcpq_pkg::*;

    logic [NBUCKETS-1:0] m;

    always_comb begin
        m = i_map & PICK_MASK;
        o_pick.found = 1'b0;
        o_pick.idx   = '0;
        for (int i = NBUCKETS - 1; i >= 0; i--) begin
            if (m[i]) begin
                o_pick.found = 1'b1;
                o_pick.idx   = ADDR_W'(i);
            end
        end
    end

endmodule

// ===== src/bucket_count_priority_queue.sv =====
// Top level of the bucket counting priority queue: counters in a RAM, total and map in flops.
// Depends on bcpq_pkg, bcpq_ram and bcpq_pick.
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   request   start / busy           i_cmd, i_value
//   result    o_valid (1-cycle)      o_got_value, o_empty_res, o_overflow
//
// For each request the counter RAM is read at the transfer edge and
// written back at the end of the following cycle, during which busy is high.
// One result per request, on o_valid in the cycle after the busy cycle; no receiver stall.
// A new request is taken only once busy falls, after the RAM read-modify-write of the last one.
// Reset is synchronous; clear empties the queue at once through per-bucket valid bits.
module bucket_count_priority_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bcpq_pkg::CMD_W-1:0]  i_cmd,
    input  logic [bcpq_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    output logic [bcpq_pkg::VALUE_W-1:0] o_got_value,
    output logic                        o_empty_res,
    output logic                        o_overflow
);
    import bcpq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_in_range;
    logic                r_found;
    logic [NBUCKETS-1:0] r_valid;
    logic [NBUCKETS-1:0] r_map;
    logic [TOTAL_W-1:0]  r_total;

    t_pick               pick;
    logic                accept;
    logic [ADDR_W-1:0]   raddr;
    logic [COUNT_W-1:0]  rdata;
    logic [COUNT_W-1:0]  count;
    logic                put_ovf;
    logic                put_ok;
    logic                get_ok;
    logic                get_empty;
    logic                we;
    logic [COUNT_W-1:0]  wdata;

    bcpq_pick u_pick (
        .i_map  (r_map),
        .o_pick (pick)
    );

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state == S_EXEC);
    assign raddr  = (t_cmd'(i_cmd) == CMD_GET) ? pick.idx : i_value;

    bcpq_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NBUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // map, total and valid bits only change in the exec cycle, so the pick made
    // at the transfer edge still holds when the counter comes back
    always_comb begin
        count     = r_valid[r_addr] ? rdata : '0;
        put_ovf   = (r_cmd == CMD_PUT) && r_in_range &&
                    ((count == '1) || (r_total == '1));
        put_ok    = (r_cmd == CMD_PUT) && r_in_range && !put_ovf;
        get_empty = (r_cmd == CMD_GET) && (r_total == '0);
        get_ok    = (r_cmd == CMD_GET) && !get_empty && r_found;
        we        = (r_state == S_EXEC) && (put_ok || get_ok);
        wdata     = put_ok ? count + COUNT_W'(1) : count - COUNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_map       <= '0;
            r_total     <= '0;
            o_valid     <= 1'b0;
            o_got_value <= '0;
            o_empty_res <= 1'b0;
            o_overflow  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state    <= S_EXEC;
                        r_cmd      <= t_cmd'(i_cmd);
                        r_addr     <= raddr;
                        r_in_range <= (32'(i_value) <= MAX_VALUE);
                        r_found    <= pick.found;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_IDLE;
                    o_valid     <= 1'b1;
                    o_got_value <= get_ok ? r_addr : '0;
                    o_empty_res <= get_empty;
                    o_overflow  <= put_ovf;
                    if (put_ok) begin
                        r_valid[r_addr] <= 1'b1;
                        r_map[r_addr]   <= 1'b1;
                        r_total         <= r_total + TOTAL_W'(1);
                    end
                    if (get_ok) begin
                        r_total <= r_total - TOTAL_W'(1);
                        if (count == COUNT_W'(1)) begin
                            r_map[r_addr] <= 1'b0;
                        end
                    end
                    if (r_cmd == CMD_CLEAR) begin
                        r_valid <= '0;
                        r_map   <= '0;
                        r_total <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/bcpq_checker.sv =====
// Port-level checker for the bucket counting priority queue, bound to the top level.
// Depends on bcpq_pkg and bucket_count_priority_queue.
module bcpq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [bcpq_pkg::VALUE_W-1:0] o_got_value,
    input logic                         o_empty_res,
    input logic                         o_overflow
);
    import bcpq_pkg::*;

    a_transfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("transfer not followed by busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_valid)
        else $error("exec phase did not end in one result");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a request");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_empty_res && o_overflow))
        else $error("empty and overflow together");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_empty_res || o_overflow) |-> (o_got_value == '0))
        else $error("value handed out with empty or overflow");

endmodule

bind bucket_count_priority_queue bcpq_checker u_bcpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_got_value (o_got_value),
    .o_empty_res (o_empty_res),
    .o_overflow  (o_overflow)
);
